FILE: hw/rtl/bfr_pkg.sv
// Shared types and constants for the byte frame receiver.
// Used by the controller, the datapath and the top level; depends on nothing.
package bfr_pkg;

	// Payload capacity and derived widths
	localparam int MAX_PAYLOAD = 32;
	localparam int ADDR_W      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);

	// Field widths fixed by the frame format
	localparam int BYTE_W  = 8;
	localparam int ID_W    = 16;
	localparam int INDEX_W = 6;
	localparam int TDATA_W = 56;

	// Configuration
	localparam logic [7:0] START_BYTE_RESET = 8'h42;
	localparam logic       REG_START_BYTE   = 1'b0;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_HEADER  = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_LEN_ERR = 2'd2,
		KIND_SUM_ERR = 2'd3
	} bfr_kind_t;

	// Parser and drain states
	typedef enum logic [3:0] {
		ST_HUNT,
		ST_ID_LO,
		ST_ID_HI,
		ST_TYPE,
		ST_EVENT,
		ST_LEN,
		ST_INVLEN,
		ST_PAYLOAD,
		ST_CHECK,
		ST_DRAIN
	} bfr_state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic      cap_id_lo;
		logic      cap_id_hi;
		logic      cap_type;
		logic      cap_event;
		logic      cap_len;
		logic      sum_add;
		logic      sum_restart;
		logic      count_clear;
		logic      store_byte;
		logic      emit;
		bfr_kind_t emit_kind;
		logic      drain_start;
		logic      drain_next;
	} bfr_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic is_start;
		logic len_ok;
		logic len_zero;
		logic pay_done;
		logic sum_ok;
		logic drain_last;
		logic out_free;
	} bfr_stat_t;

endpackage

FILE: hw/rtl/bfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; contents are undefined until written.
module bfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic                                         re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port; hold data between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: hw/rtl/bfr_ctrl.sv
// Frame parser state machine: walks the header, payload and checksum bytes,
// then drains the stored payload. Uses bfr_pkg for states and command types.
module bfr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  bfr_pkg::bfr_stat_t stat,
	output bfr_pkg::bfr_cmd_t  cmd
);

	bfr_pkg::bfr_state_t state_q;
	bfr_pkg::bfr_state_t state_d;
	logic                ready;
	logic                fire;

	// Stall input during drain, and on result-producing bytes while output is busy
	always_comb begin
		ready = (state_q != bfr_pkg::ST_DRAIN) &&
			(stat.out_free ||
			 ((state_q != bfr_pkg::ST_INVLEN) && (state_q != bfr_pkg::ST_CHECK)));
		fire  = in_valid && ready;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bfr_pkg::ST_HUNT: begin
				if (fire && stat.is_start) state_d = bfr_pkg::ST_ID_LO;
			end
			bfr_pkg::ST_ID_LO: begin
				if (fire) state_d = bfr_pkg::ST_ID_HI;
			end
			bfr_pkg::ST_ID_HI: begin
				if (fire) state_d = bfr_pkg::ST_TYPE;
			end
			bfr_pkg::ST_TYPE: begin
				if (fire) state_d = bfr_pkg::ST_EVENT;
			end
			bfr_pkg::ST_EVENT: begin
				if (fire) state_d = bfr_pkg::ST_LEN;
			end
			bfr_pkg::ST_LEN: begin
				if (fire) state_d = bfr_pkg::ST_INVLEN;
			end
			bfr_pkg::ST_INVLEN: begin
				if (fire) begin
					if (!stat.len_ok) state_d = bfr_pkg::ST_HUNT;
					else if (stat.len_zero) state_d = bfr_pkg::ST_CHECK;
					else state_d = bfr_pkg::ST_PAYLOAD;
				end
			end
			bfr_pkg::ST_PAYLOAD: begin
				if (fire && stat.pay_done) state_d = bfr_pkg::ST_CHECK;
			end
			bfr_pkg::ST_CHECK: begin
				if (fire) begin
					if (stat.sum_ok && !stat.len_zero) state_d = bfr_pkg::ST_DRAIN;
					else state_d = bfr_pkg::ST_HUNT;
				end
			end
			bfr_pkg::ST_DRAIN: begin
				if (stat.out_free && stat.drain_last) state_d = bfr_pkg::ST_HUNT;
			end
			default: begin
				state_d = bfr_pkg::ST_HUNT;
			end
		endcase
	end

	// Outputs
	always_comb begin
		cmd           = '0;
		cmd.emit_kind = bfr_pkg::KIND_HEADER;
		cmd.sum_add   = fire;
		case (state_q)
			bfr_pkg::ST_HUNT: begin
				cmd.sum_restart = fire && stat.is_start;
			end
			bfr_pkg::ST_ID_LO: begin
				cmd.cap_id_lo = fire;
			end
			bfr_pkg::ST_ID_HI: begin
				cmd.cap_id_hi = fire;
			end
			bfr_pkg::ST_TYPE: begin
				cmd.cap_type = fire;
			end
			bfr_pkg::ST_EVENT: begin
				cmd.cap_event = fire;
			end
			bfr_pkg::ST_LEN: begin
				cmd.cap_len = fire;
			end
			bfr_pkg::ST_INVLEN: begin
				cmd.emit        = fire && !stat.len_ok;
				cmd.emit_kind   = bfr_pkg::KIND_LEN_ERR;
				cmd.count_clear = fire && stat.len_ok;
			end
			bfr_pkg::ST_PAYLOAD: begin
				cmd.store_byte = fire;
			end
			bfr_pkg::ST_CHECK: begin
				cmd.emit        = fire;
				cmd.emit_kind   = stat.sum_ok ? bfr_pkg::KIND_HEADER : bfr_pkg::KIND_SUM_ERR;
				cmd.drain_start = fire && stat.sum_ok && !stat.len_zero;
			end
			bfr_pkg::ST_DRAIN: begin
				cmd.emit       = stat.out_free;
				cmd.emit_kind  = bfr_pkg::KIND_PAYLOAD;
				cmd.drain_next = stat.out_free;
			end
			default: begin
				cmd.sum_add = fire;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfr_pkg::ST_HUNT;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = ready;

endmodule

FILE: hw/rtl/bfr_dpath.sv
// Frame datapath: header registers, running checksum, payload store and the
// result output register. Uses bfr_pkg and bfr_ram.
module bfr_dpath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [bfr_pkg::BYTE_W-1:0]    rx_byte,
	input  logic [bfr_pkg::BYTE_W-1:0]    start_byte,
	input  bfr_pkg::bfr_cmd_t             cmd,
	output bfr_pkg::bfr_stat_t            stat,
	output logic                          out_valid,
	input  logic                          out_ready,
	output bfr_pkg::bfr_kind_t            out_kind,
	output logic [bfr_pkg::ID_W-1:0]      out_msg_id,
	output logic [bfr_pkg::BYTE_W-1:0]    out_msg_type,
	output logic [bfr_pkg::BYTE_W-1:0]    out_event_code,
	output logic [bfr_pkg::BYTE_W-1:0]    out_payload_len,
	output logic                          out_truncated,
	output logic [bfr_pkg::BYTE_W-1:0]    out_data_byte,
	output logic [bfr_pkg::INDEX_W-1:0]   out_byte_index,
	output logic                          out_last
);

	// Header and checksum state
	logic [bfr_pkg::ID_W-1:0]    id_q;
	logic [bfr_pkg::BYTE_W-1:0]  type_q;
	logic [bfr_pkg::BYTE_W-1:0]  event_q;
	logic [bfr_pkg::BYTE_W-1:0]  length_q;
	logic [bfr_pkg::BYTE_W-1:0]  sum_q;
	logic [bfr_pkg::BYTE_W-1:0]  count_q;
	logic [bfr_pkg::ADDR_W-1:0]  rd_idx_q;

	// Result register
	logic                        valid_q;
	bfr_pkg::bfr_kind_t          kind_q;
	logic [bfr_pkg::ID_W-1:0]    o_id_q;
	logic [bfr_pkg::BYTE_W-1:0]  o_type_q;
	logic [bfr_pkg::BYTE_W-1:0]  o_event_q;
	logic [bfr_pkg::BYTE_W-1:0]  o_len_q;
	logic                        o_trunc_q;
	logic [bfr_pkg::BYTE_W-1:0]  o_data_q;
	logic [bfr_pkg::INDEX_W-1:0] o_index_q;
	logic                        o_last_q;

	logic                        truncated;
	logic [bfr_pkg::CNT_W-1:0]   stored;
	logic [bfr_pkg::CNT_W-1:0]   rd_idx_next_cnt;
	logic                        drain_last;
	logic                        out_free;
	logic [bfr_pkg::BYTE_W:0]    count_inc;
	logic                        store_we;
	logic                        ram_re;
	logic [bfr_pkg::ADDR_W-1:0]  ram_raddr;
	logic [bfr_pkg::BYTE_W-1:0]  ram_rdata;

	// Derived frame quantities
	always_comb begin
		truncated       = length_q > bfr_pkg::BYTE_W'(bfr_pkg::MAX_PAYLOAD);
		stored          = truncated ? bfr_pkg::CNT_W'(bfr_pkg::MAX_PAYLOAD)
			: length_q[bfr_pkg::CNT_W-1:0];
		rd_idx_next_cnt = bfr_pkg::CNT_W'(rd_idx_q) + bfr_pkg::CNT_W'(1);
		drain_last      = rd_idx_next_cnt == stored;
		out_free        = !valid_q || out_ready;
		count_inc       = {1'b0, count_q} + 9'd1;
	end

	// Status to the controller
	always_comb begin
		stat.is_start   = rx_byte == start_byte;
		stat.len_ok     = length_q == ~rx_byte;
		stat.len_zero   = length_q == '0;
		stat.pay_done   = count_inc >= {1'b0, length_q};
		stat.sum_ok     = rx_byte == sum_q;
		stat.drain_last = drain_last;
		stat.out_free   = out_free;
	end

	// Capture header fields
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_q     <= '0;
			type_q   <= '0;
			event_q  <= '0;
			length_q <= '0;
		end else begin
			if (cmd.cap_id_lo) id_q[7:0]  <= rx_byte;
			if (cmd.cap_id_hi) id_q[15:8] <= rx_byte;
			if (cmd.cap_type)  type_q     <= rx_byte;
			if (cmd.cap_event) event_q    <= rx_byte;
			if (cmd.cap_len)   length_q   <= rx_byte;
		end
	end

	// Running checksum and payload counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
		end else begin
			if (cmd.sum_add) begin
				sum_q <= (cmd.sum_restart ? '0 : sum_q) + rx_byte;
			end
			if (cmd.count_clear) begin
				count_q <= '0;
			end else if (cmd.store_byte) begin
				count_q <= count_inc[bfr_pkg::BYTE_W-1:0];
			end
		end
	end

	// Store payload bytes up to capacity; drop the rest
	assign store_we = cmd.store_byte && (count_q < bfr_pkg::BYTE_W'(bfr_pkg::MAX_PAYLOAD));

	// Drain read address: first entry, then one ahead of the entry being shown
	always_comb begin
		ram_re    = cmd.drain_start || (cmd.drain_next && !drain_last);
		ram_raddr = cmd.drain_start ? '0 : bfr_pkg::ADDR_W'(rd_idx_next_cnt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q <= '0;
		end else if (cmd.drain_start) begin
			rd_idx_q <= '0;
		end else if (cmd.drain_next && !drain_last) begin
			rd_idx_q <= bfr_pkg::ADDR_W'(rd_idx_next_cnt);
		end
	end

	bfr_ram #(
		.WIDTH (bfr_pkg::BYTE_W),
		.DEPTH (bfr_pkg::MAX_PAYLOAD)
	) u_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (count_q[bfr_pkg::ADDR_W-1:0]),
		.wdata (rx_byte),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Result valid: set on emit, clear when the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.emit) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// Result payload: header fields on every result, data only for payload bytes
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			kind_q    <= cmd.emit_kind;
			o_id_q    <= id_q;
			o_type_q  <= type_q;
			o_event_q <= event_q;
			o_len_q   <= length_q;
			o_trunc_q <= truncated;
			o_data_q  <= '0;
			o_index_q <= '0;
			case (cmd.emit_kind)
				bfr_pkg::KIND_HEADER: begin
					o_last_q <= length_q == '0;
				end
				bfr_pkg::KIND_PAYLOAD: begin
					o_data_q  <= ram_rdata;
					o_index_q <= bfr_pkg::INDEX_W'(rd_idx_q);
					o_last_q  <= drain_last;
				end
				default: begin
					o_last_q <= 1'b1;
				end
			endcase
		end
	end

	assign out_valid       = valid_q;
	assign out_kind        = kind_q;
	assign out_msg_id      = o_id_q;
	assign out_msg_type    = o_type_q;
	assign out_event_code  = o_event_q;
	assign out_payload_len = o_len_q;
	assign out_truncated   = o_trunc_q;
	assign out_data_byte   = o_data_q;
	assign out_byte_index  = o_index_q;
	assign out_last        = o_last_q;

endmodule

FILE: hw/rtl/byte_frame_receiver.sv
// Byte frame receiver top level: stream ports, APB register and assertions.
// Depends on bfr_pkg, bfr_ctrl, bfr_dpath and bfr_ram.
//
// Usage:
//   Received bytes enter on the s_axis stream, one per transfer. The block
//   hunts for the start byte (APB register at address 0, 0x42 after reset),
//   then reads id low, id high, type, event, length, inverted length, the
//   payload and a checksum byte (8-bit sum from the start byte on).
//   Results leave on m_axis: tuser holds the kind (header, payload byte,
//   length error, checksum error), tlast marks the final result of a frame.
//   A result is registered and shows in the cycle after the transfer of the
//   byte that causes it. Input takes one byte per cycle while parsing.
//   A good checksum gives the header, then one stored payload byte per cycle
//   read from the payload RAM (one read port), up to 32 bytes; input stalls
//   for that drain. Longer payloads are counted but not stored (truncated).
//   Reset: the parser hunts for the start byte; the payload RAM is not
//   cleared. When m_axis_tready is low the result register holds, and input
//   stalls only on the inverted-length and checksum bytes and during drain.
module byte_frame_receiver (
	input  logic        clk,
	input  logic        arst_n,
	// APB register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Byte input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
	// Result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [15:0] msg_id, [23:16] msg_type, [31:24] event_code, [39:32] payload_len,
	// [40] truncated, [48:41] data_byte, [54:49] byte_index, [55] zero
	output logic [55:0] m_axis_tdata,
	output logic [1:0]  m_axis_tuser,  // [1:0] kind
	output logic        m_axis_tlast
);

	logic [bfr_pkg::BYTE_W-1:0]  start_byte_q;
	logic                        cfg_we;
	bfr_pkg::bfr_cmd_t           cmd;
	bfr_pkg::bfr_stat_t          stat;
	bfr_pkg::bfr_kind_t          out_kind;
	logic [bfr_pkg::ID_W-1:0]    out_msg_id;
	logic [bfr_pkg::BYTE_W-1:0]  out_msg_type;
	logic [bfr_pkg::BYTE_W-1:0]  out_event_code;
	logic [bfr_pkg::BYTE_W-1:0]  out_payload_len;
	logic                        out_truncated;
	logic [bfr_pkg::BYTE_W-1:0]  out_data_byte;
	logic [bfr_pkg::INDEX_W-1:0] out_byte_index;

	// Register write on the access cycle
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == bfr_pkg::REG_START_BYTE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= bfr_pkg::START_BYTE_RESET;
		end else if (cfg_we) begin
			start_byte_q <= pwdata[7:0];
		end
	end

	// Register read
	always_comb begin
		prdata = '0;
		if (paddr[2] == bfr_pkg::REG_START_BYTE) begin
			prdata = {24'd0, start_byte_q};
		end
	end

	bfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	bfr_dpath u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.rx_byte         (s_axis_tdata),
		.start_byte      (start_byte_q),
		.cmd             (cmd),
		.stat            (stat),
		.out_valid       (m_axis_tvalid),
		.out_ready       (m_axis_tready),
		.out_kind        (out_kind),
		.out_msg_id      (out_msg_id),
		.out_msg_type    (out_msg_type),
		.out_event_code  (out_event_code),
		.out_payload_len (out_payload_len),
		.out_truncated   (out_truncated),
		.out_data_byte   (out_data_byte),
		.out_byte_index  (out_byte_index),
		.out_last        (m_axis_tlast)
	);

	// Pack result fields, lowest field first
	assign m_axis_tuser = out_kind;
	assign m_axis_tdata = {1'b0, out_byte_index, out_data_byte, out_truncated,
		out_payload_len, out_event_code, out_msg_type, out_msg_id};

	// A new result never overwrites one still waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!m_axis_tvalid || m_axis_tready))
		else $error("result register overwritten");

	// Input stays stalled in the cycle after a drain starts
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.drain_start |=> !s_axis_tready)
		else $error("input accepted during payload drain");

	// Payload bytes are stored only on an input transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store_byte |-> (s_axis_tvalid && s_axis_tready))
		else $error("payload stored without transfer");

	// Error results always end their run
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser == bfr_pkg::KIND_LEN_ERR ||
			m_axis_tuser == bfr_pkg::KIND_SUM_ERR)) |-> m_axis_tlast)
		else $error("error result without tlast");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the byte frame receiver: drives byte streams and
// APB writes, predicts every result in a scoreboard class. Depends on bfr_pkg.
`timescale 1ns / 1ps
module testbench;

	localparam int WATCHDOG_LIMIT = 2000;

	// One expected result, field by field
	typedef struct {
		bfr_pkg::bfr_kind_t kind;
		logic [15:0]        msg_id;
		logic [7:0]         msg_type;
		logic [7:0]         event_code;
		logic [7:0]         payload_len;
		logic               truncated;
		logic [7:0]         data_byte;
		logic [5:0]         byte_index;
		logic               last;
	} frame_result_t;

	// Parser copy and store of expected results
	class frame_scoreboard;
		logic [7:0]          start_byte;
		bfr_pkg::bfr_state_t parse_pos;
		logic [15:0]         id_q;
		logic [7:0]          type_q;
		logic [7:0]          event_q;
		logic [7:0]          len_q;
		logic [7:0]          pay_count;
		logic [7:0]          frame_sum;
		logic [7:0]          pay_store [bfr_pkg::MAX_PAYLOAD];
		frame_result_t       pending_results [$];
		int                  errors;
		int                  checked;

		function new();
			start_byte = bfr_pkg::START_BYTE_RESET;
			parse_pos  = bfr_pkg::ST_HUNT;
			id_q       = '0;
			type_q     = '0;
			event_q    = '0;
			len_q      = '0;
			pay_count  = '0;
			frame_sum  = '0;
			errors     = 0;
			checked    = 0;
			foreach (pay_store[i]) pay_store[i] = '0;
		endfunction

		function void set_start(input logic [7:0] value);
			start_byte = value;
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		function void add_result(input bfr_pkg::bfr_kind_t kind, input logic [7:0] data,
				input int index, input logic last);
			frame_result_t r;
			r.kind        = kind;
			r.msg_id      = id_q;
			r.msg_type    = type_q;
			r.event_code  = event_q;
			r.payload_len = len_q;
			r.truncated   = (len_q > bfr_pkg::MAX_PAYLOAD);
			r.data_byte   = data;
			r.byte_index  = 6'(index);
			r.last        = last;
			pending_results.push_back(r);
		endfunction

		// Advance the parser by one accepted byte
		function void note_byte(input logic [7:0] b);
			int stored;
			case (parse_pos)
				bfr_pkg::ST_HUNT: begin
					if (b == start_byte) begin
						parse_pos = bfr_pkg::ST_ID_LO;
						frame_sum = '0;
					end
				end
				bfr_pkg::ST_ID_LO: begin
					id_q[7:0] = b;
					parse_pos = bfr_pkg::ST_ID_HI;
				end
				bfr_pkg::ST_ID_HI: begin
					id_q[15:8] = b;
					parse_pos  = bfr_pkg::ST_TYPE;
				end
				bfr_pkg::ST_TYPE: begin
					type_q    = b;
					parse_pos = bfr_pkg::ST_EVENT;
				end
				bfr_pkg::ST_EVENT: begin
					event_q   = b;
					parse_pos = bfr_pkg::ST_LEN;
				end
				bfr_pkg::ST_LEN: begin
					len_q     = b;
					parse_pos = bfr_pkg::ST_INVLEN;
				end
				bfr_pkg::ST_INVLEN: begin
					if (len_q != ~b) begin
						add_result(bfr_pkg::KIND_LEN_ERR, 8'h00, 0, 1'b1);
						parse_pos = bfr_pkg::ST_HUNT;
					end else begin
						pay_count = '0;
						parse_pos = (len_q == 0) ? bfr_pkg::ST_CHECK : bfr_pkg::ST_PAYLOAD;
					end
				end
				bfr_pkg::ST_PAYLOAD: begin
					// keep the first MAX_PAYLOAD bytes, count the rest
					if (pay_count < bfr_pkg::MAX_PAYLOAD) pay_store[pay_count] = b;
					pay_count = pay_count + 8'd1;
					if (pay_count >= len_q) begin
						pay_count = '0;
						parse_pos = bfr_pkg::ST_CHECK;
					end
				end
				bfr_pkg::ST_CHECK: begin
					parse_pos = bfr_pkg::ST_HUNT;
					if (b != frame_sum) begin
						add_result(bfr_pkg::KIND_SUM_ERR, 8'h00, 0, 1'b1);
					end else begin
						stored = (len_q > bfr_pkg::MAX_PAYLOAD) ? bfr_pkg::MAX_PAYLOAD
							: int'(len_q);
						add_result(bfr_pkg::KIND_HEADER, 8'h00, 0, stored == 0);
						for (int i = 0; i < stored; i++)
							add_result(bfr_pkg::KIND_PAYLOAD, pay_store[i], i,
								i + 1 == stored);
					end
				end
				default: parse_pos = bfr_pkg::ST_HUNT;
			endcase
			frame_sum = frame_sum + b;
		endfunction

		task report_mismatch(input string msg);
			$display("ERROR at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task compare_field(input string name, input logic [15:0] got,
				input logic [15:0] want);
			if (got !== want)
				report_mismatch($sformatf("result %0d %s: got %h, want %h",
					checked, name, got, want));
		endtask

		// Compare one transfer on the result stream with the oldest expectation
		task check_result(input logic [55:0] tdata, input logic [1:0] tuser,
				input logic tlast);
			frame_result_t e;
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result %0d with none expected: user %h data %h",
					checked, tuser, tdata));
			end else begin
				e = pending_results.pop_front();
				compare_field("kind", 16'(tuser), 16'(e.kind));
				compare_field("msg_id", tdata[15:0], e.msg_id);
				compare_field("msg_type", 16'(tdata[23:16]), 16'(e.msg_type));
				compare_field("event_code", 16'(tdata[31:24]), 16'(e.event_code));
				compare_field("payload_len", 16'(tdata[39:32]), 16'(e.payload_len));
				compare_field("truncated", 16'(tdata[40]), 16'(e.truncated));
				compare_field("data_byte", 16'(tdata[48:41]), 16'(e.data_byte));
				compare_field("byte_index", 16'(tdata[54:49]), 16'(e.byte_index));
				compare_field("pad", 16'(tdata[55]), 16'h0);
				compare_field("last", 16'(tlast), 16'(e.last));
			end
			checked++;
		endtask
	endclass

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        psel          = 1'b0;
	logic        penable       = 1'b0;
	logic        pwrite        = 1'b0;
	logic [2:0]  paddr         = '0;
	logic [31:0] pwdata        = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = '0;   // [7:0] rx_byte
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// [15:0] msg_id, [23:16] msg_type, [31:24] event_code, [39:32] payload_len,
	// [40] truncated, [48:41] data_byte, [54:49] byte_index, [55] zero
	logic [55:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;         // [1:0] kind
	logic        m_axis_tlast;

	frame_scoreboard sb;
	logic [7:0]      cur_start = bfr_pkg::START_BYTE_RESET;
	logic [7:0]      wire_sum;
	int              items_sent = 0;
	bit              no_idle    = 1'b0;
	int              out_stall  = 0;
	int              quiet_cycles;

	byte_frame_receiver uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Stall the result stream in short random bursts
	always @(posedge clk) begin
		if (out_stall > 0) begin
			m_axis_tready <= 1'b0;
			out_stall--;
		end else if (!no_idle && $urandom_range(0, 5) == 0) begin
			m_axis_tready <= 1'b0;
			out_stall = $urandom_range(0, 2);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Check every result transfer
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
	end

	// Drop the run when no transfer happens for too long
	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
		$display("byte_frame_receiver: mismatch");
		$finish;
	end

	// Offer one byte, with an optional gap first, and hold it until the transfer
	task automatic send_byte(input logic [7:0] b, input bit counted);
		if (!no_idle && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
		sb.note_byte(b);
		wire_sum = wire_sum + b;
		if (counted) items_sent++;
	endtask

	// Send a whole frame; a broken length ends it after the inverted length
	task automatic send_frame(input logic [15:0] id, input logic [7:0] ftype,
			input logic [7:0] evt, input logic [7:0] len, input bit bad_len,
			input bit bad_sum);
		logic [7:0] inv;
		logic [7:0] sum_byte;
		wire_sum = '0;
		send_byte(cur_start, 1'b1);
		send_byte(id[7:0], 1'b1);
		send_byte(id[15:8], 1'b1);
		send_byte(ftype, 1'b1);
		send_byte(evt, 1'b1);
		send_byte(len, 1'b1);
		inv = ~len;
		if (bad_len) inv = inv ^ 8'($urandom_range(1, 255));
		send_byte(inv, 1'b1);
		if (!bad_len) begin
			for (int i = 0; i < int'(len); i++) send_byte(8'($urandom), 1'b1);
			sum_byte = wire_sum;
			if (bad_sum) sum_byte = sum_byte ^ 8'($urandom_range(1, 255));
			send_byte(sum_byte, 1'b1);
		end
	endtask

	// Mostly well-formed frames, some broken ones and some line noise
	task automatic run_random(input int n_items);
		int         target;
		int         pick;
		int         r;
		logic [7:0] len;
		logic [7:0] noise;
		target = items_sent + n_items;
		while (items_sent < target) begin
			pick = $urandom_range(0, 99);
			r    = $urandom_range(0, 99);
			if (r < 70)      len = 8'($urandom_range(0, 8));
			else if (r < 92) len = 8'($urandom_range(9, bfr_pkg::MAX_PAYLOAD));
			else             len = 8'($urandom_range(bfr_pkg::MAX_PAYLOAD + 1, 48));
			if (pick < 70) begin
				send_frame(16'($urandom), 8'($urandom), 8'($urandom), len, 1'b0, 1'b0);
			end else if (pick < 80) begin
				send_frame(16'($urandom), 8'($urandom), 8'($urandom), len, 1'b0, 1'b1);
			end else if (pick < 90) begin
				send_frame(16'($urandom), 8'($urandom), 8'($urandom), len, 1'b1, 1'b0);
			end else begin
				repeat ($urandom_range(1, 3)) begin
					noise = 8'($urandom);
					if (noise == cur_start) noise = noise ^ 8'h01;
					send_byte(noise, 1'b0);
				end
			end
		end
	endtask

	// Stop offering bytes and let every expected result drain
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() > 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// APB write of the start byte: setup cycle, then access cycle
	task automatic write_start(input logic [7:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {bfr_pkg::REG_START_BYTE, 2'b00};
		pwdata  <= {24'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.set_start(value);
		cur_start = value;
	endtask

	initial begin
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: ignored byte, empty good frame, length error, bad checksum
		send_byte(8'h00, 1'b0);
		send_frame(16'hFFFF, 8'h00, 8'hFF, 8'h00, 1'b0, 1'b0);
		send_frame(16'h0000, 8'hFF, 8'h00, 8'hFF, 1'b1, 1'b0);
		send_frame(16'h00FF, 8'hA5, 8'h5A, 8'h01, 1'b0, 1'b1);
		run_random(30);
		settle();

		// Extreme start byte, payload at and past capacity, longest length
		write_start(8'hFF);
		send_frame(16'($urandom), 8'($urandom), 8'($urandom), 8'(bfr_pkg::MAX_PAYLOAD),
			1'b0, 1'b0);
		send_frame(16'($urandom), 8'($urandom), 8'($urandom),
			8'(bfr_pkg::MAX_PAYLOAD + 1), 1'b0, 1'b0);
		send_frame(16'($urandom), 8'($urandom), 8'($urandom), 8'hFF, 1'b0, 1'b0);
		run_random(20);
		settle();

		write_start(8'h00);
		run_random(20);
		settle();

		write_start(8'($urandom));
		run_random(20);
		settle();

		// Last part: back to the reset value, no idling on either side
		no_idle = 1'b1;
		write_start(bfr_pkg::START_BYTE_RESET);
		run_random(20);
		settle();
		repeat (6) @(posedge clk);

		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("byte_frame_receiver: match");
		end else begin
			$display("byte_frame_receiver: mismatch");
		end
		$finish;
	end
endmodule
